// ===== rtl/vmpr_pkg.sv =====
package vmpr_pkg;

  // Request kinds on the input channel.
  localparam logic [1:0] ACT_RENDER   = 2'd0;
  localparam logic [1:0] ACT_WR_VIDEO = 2'd1;
  localparam logic [1:0] ACT_WR_GLYPH = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GFX_EN = 2'd0;
  localparam logic [1:0] CFG_CSS    = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  // Graphics modes: resolution and colour depth.
  localparam logic [2:0] MODE_64X64_C4   = 3'd0;
  localparam logic [2:0] MODE_128X64_C2  = 3'd1;
  localparam logic [2:0] MODE_128X64_C4  = 3'd2;
  localparam logic [2:0] MODE_128X96_C2  = 3'd3;
  localparam logic [2:0] MODE_128X96_C4  = 3'd4;
  localparam logic [2:0] MODE_128X192_C2 = 3'd5;
  localparam logic [2:0] MODE_128X192_C4 = 3'd6;
  localparam logic [2:0] MODE_256X192_C2 = 3'd7;

  // Palette indexes used by character mode.
  localparam logic [3:0] COLOUR_FG = 4'd0;
  localparam logic [3:0] COLOUR_BG = 4'd8;

  typedef struct packed {
    logic       gfx_en;
    logic       css;
    logic [2:0] mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  x;
    logic [12:0] addr;
    logic [7:0]  data;
  } item_t;

  // Request leaving the coordinate stages, ready for the video memory.
  typedef struct packed {
    item_t       item;
    logic [12:0] vaddr;
    logic        vaddr_oor;
    logic [3:0]  line;
  } fetch_t;

  // Request leaving the video memory stage with its fetched byte.
  typedef struct packed {
    item_t      item;
    logic [3:0] line;
    logic [7:0] code;
  } code_t;

endpackage

// ===== rtl/vmpr_coord.sv =====
module vmpr_coord #(
  parameter int GLYPH_ROWS  = 12,
  parameter int VIDEO_BYTES = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  vmpr_pkg::item_t  in_item,
  input  logic [7:0]       in_y,
  input  vmpr_pkg::cfg_t   cfg,
  input  logic             s1_en,
  input  logic             s2_en,
  output logic             s1_vld,
  output logic             s2_vld,
  output vmpr_pkg::fetch_t fetch
);
  import vmpr_pkg::*;

  // Division by a small constant as a multiply by a rounded-up reciprocal.
  // Both are exact for every 8-bit dividend.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_G     = ((1 << RECIP_SHIFT) + GLYPH_ROWS - 1) / GLYPH_ROWS;
  localparam int DIV3_SHIFT  = 9;
  localparam int RECIP_3     = ((1 << DIV3_SHIFT) + 2) / 3;

  logic        s1_vld_r;
  item_t       s1_item_r;
  logic [7:0]  s1_y_r;

  logic        s2_vld_r;
  item_t       s2_item_r;
  logic [7:0]  s2_y_r;
  logic [4:0]  s2_qg_r;
  logic [6:0]  s2_y3_r;

  logic [24:0] prod_g_w;
  logic [15:0] prod_3_w;
  logic [9:0]  qg_times_w;
  logic [9:0]  line_full_w;
  logic [12:0] vaddr_w;

  // Stage 1: capture the request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_item_r <= in_item;
      s1_y_r    <= in_y;
    end
  end

  assign prod_g_w = 25'(s1_y_r) * 25'(RECIP_G);
  assign prod_3_w = 16'(s1_y_r) * 16'(RECIP_3);

  // Stage 2: text row and line-by-three quotients.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_item_r <= s1_item_r;
      s2_y_r    <= s1_y_r;
      s2_qg_r   <= prod_g_w[RECIP_SHIFT +: 5];
      s2_y3_r   <= prod_3_w[DIV3_SHIFT +: 7];
    end
  end

  assign qg_times_w  = 10'(s2_qg_r) * 10'(GLYPH_ROWS);
  assign line_full_w = 10'(s2_y_r) - qg_times_w;

  always_comb begin
    vaddr_w = '0;
    if (!cfg.gfx_en) begin
      vaddr_w = {3'b000, s2_qg_r, s2_item_r.x[7:3]};
    end else begin
      unique case (cfg.mode) inside
        MODE_256X192_C2, MODE_128X192_C4:
          vaddr_w = {s2_y_r, s2_item_r.x[7:3]};
        MODE_128X192_C2:
          vaddr_w = {1'b0, s2_y_r, s2_item_r.x[7:4]};
        MODE_128X96_C4:
          vaddr_w = {1'b0, s2_y_r[7:1], s2_item_r.x[7:3]};
        MODE_128X96_C2:
          vaddr_w = {2'b00, s2_y_r[7:1], s2_item_r.x[7:4]};
        MODE_128X64_C4:
          vaddr_w = {1'b0, s2_y3_r, s2_item_r.x[7:3]};
        MODE_128X64_C2, MODE_64X64_C4:
          vaddr_w = {2'b00, s2_y3_r, s2_item_r.x[7:4]};
        default:
          vaddr_w = '0;
      endcase
    end
  end

  assign s1_vld          = s1_vld_r;
  assign s2_vld          = s2_vld_r;
  assign fetch.item      = s2_item_r;
  assign fetch.vaddr     = vaddr_w;
  assign fetch.vaddr_oor = {1'b0, vaddr_w} >= 14'(VIDEO_BYTES);
  assign fetch.line      = line_full_w[3:0];

endmodule

// ===== rtl/vmpr_vram.sv =====
module vmpr_vram #(
  parameter int VIDEO_BYTES = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s2_vld,
  input  vmpr_pkg::fetch_t fetch,
  input  logic             s3_en,
  output logic             s3_vld,
  output vmpr_pkg::code_t  code
);
  import vmpr_pkg::*;

  localparam int VA_W = $clog2(VIDEO_BYTES);

  logic [7:0] mem [VIDEO_BYTES];
  logic [7:0] rd_r;
  logic       s3_vld_r;
  item_t      s3_item_r;
  logic [3:0] s3_line_r;
  logic       s3_oor_r;
  logic       wr_w;

  // Reads and writes both happen here, so requests see memory in order.
  assign wr_w = s3_en && s2_vld && (fetch.item.act == ACT_WR_VIDEO) &&
                ({1'b0, fetch.item.addr} < 14'(VIDEO_BYTES));

  always_ff @(posedge clk) begin
    if (wr_w) begin
      mem[fetch.item.addr[VA_W-1:0]] <= fetch.item.data;
    end
    if (s3_en) begin
      rd_r <= mem[fetch.vaddr[VA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_en) begin
      s3_vld_r <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_item_r <= fetch.item;
      s3_line_r <= fetch.line;
      s3_oor_r  <= fetch.vaddr_oor;
    end
  end

  assign s3_vld    = s3_vld_r;
  assign code.item = s3_item_r;
  assign code.line = s3_line_r;
  assign code.code = s3_oor_r ? 8'h00 : rd_r;

endmodule

// ===== rtl/vmpr_glyph.sv =====
module vmpr_glyph #(
  parameter int GLYPH_ROWS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s3_vld,
  input  vmpr_pkg::code_t code,
  input  vmpr_pkg::cfg_t  cfg,
  input  logic            s4_en,
  output logic            s4_vld,
  output logic            s4_render,
  output logic [3:0]      colour
);
  import vmpr_pkg::*;

  localparam int GLYPH_BYTES = 256 * GLYPH_ROWS;
  localparam int GA_W        = $clog2(GLYPH_BYTES);

  logic [7:0]  mem [GLYPH_BYTES];
  logic [7:0]  glyph_r;
  logic        s4_vld_r;
  logic [1:0]  s4_act_r;
  logic [2:0]  s4_xl_r;
  logic [7:0]  s4_code_r;
  logic [3:0]  s4_gfx_r;

  logic [12:0] gaddr_w;
  logic        wr_w;
  logic [7:0]  pair_sh_w;
  logic [1:0]  pix_w;
  logic        set_w;
  logic [3:0]  char_w;

  assign gaddr_w = 13'(code.code) * 13'(GLYPH_ROWS) + 13'(code.line);
  assign wr_w    = s4_en && s3_vld && (code.item.act == ACT_WR_GLYPH) &&
                   (code.item.addr < 13'(GLYPH_BYTES));

  always_ff @(posedge clk) begin
    if (wr_w) begin
      mem[code.item.addr[GA_W-1:0]] <= code.item.data;
    end
    if (s4_en) begin
      glyph_r <= mem[gaddr_w[GA_W-1:0]];
    end
  end

  // Graphics pixel: the leftmost pixel of a byte sits in its top bits.
  always_comb begin
    pair_sh_w = 8'h00;
    pix_w     = 2'b00;
    unique case (cfg.mode) inside
      MODE_256X192_C2:
        pix_w = {1'b1, code.code[~code.item.x[2:0]]};
      MODE_128X192_C2, MODE_128X96_C2, MODE_128X64_C2:
        pix_w = {1'b1, code.code[~code.item.x[3:1]]};
      MODE_128X192_C4, MODE_128X96_C4, MODE_128X64_C4: begin
        pair_sh_w = code.code >> {~code.item.x[2:1], 1'b0};
        pix_w     = pair_sh_w[1:0];
      end
      MODE_64X64_C4: begin
        pair_sh_w = code.code >> {~code.item.x[3:2], 1'b0};
        pix_w     = pair_sh_w[1:0];
      end
      default: pix_w = 2'b00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (s4_en) begin
      s4_vld_r <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_act_r  <= code.item.act;
      s4_xl_r   <= code.item.x[2:0];
      s4_code_r <= code.code;
      s4_gfx_r  <= {1'b0, cfg.css, pix_w};
    end
  end

  // Glyph rows are drawn LSB first; codes with the top bit set are semigraphic.
  assign set_w = glyph_r[s4_xl_r];

  always_comb begin
    if (s4_code_r[7]) begin
      char_w = set_w ? COLOUR_BG : {1'b0, s4_code_r[6:4]};
    end else begin
      char_w = set_w ? COLOUR_FG : COLOUR_BG;
    end
  end

  assign s4_vld    = s4_vld_r;
  assign s4_render = (s4_act_r == ACT_RENDER);
  assign colour    = cfg.gfx_en ? s4_gfx_r : char_w;

endmodule

// ===== rtl/video_mode_pixel_renderer_top.sv =====
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_stall   action, pixel_x, pixel_y, mem_addr, mem_data
// out_      result     out_valid/out_stall colour_index
// cfg_      write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request is taken every clock while in_stall is low. A render request comes
// out through two coordinate stages, the video RAM read, the glyph RAM read and
// the output register; write requests give no result.
// Reset is synchronous and clears the valid bits and the configuration; both
// memories hold unknown data until written. A stalled output holds only the
// stages that are full behind it, so bubbles close up while out_stall is high.
module video_mode_pixel_renderer_top #(
  parameter int VIDEO_BYTES = 8192,
  parameter int GLYPH_ROWS  = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic [12:0] in_mem_addr,
  input  logic [7:0]  in_mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_colour_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import vmpr_pkg::*;

  cfg_t       cfg_r;
  item_t      in_item_w;
  fetch_t     fetch_w;
  code_t      code_w;

  logic       s1_vld, s2_vld, s3_vld, s4_vld, s4_render;
  logic       s1_en, s2_en, s3_en, s4_en, s5_en;
  logic [3:0] colour_w;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [3:0] out_colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GFX_EN: cfg_r.gfx_en <= cfg_data[0];
        CFG_CSS:    cfg_r.css    <= cfg_data[0];
        CFG_MODE:   cfg_r.mode   <= cfg_data;
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // A stage loads when it is empty or when the stage after it moves.
  assign s5_en = !out_valid_r || !out_stall;
  assign s4_en = !s4_vld || s5_en;
  assign s3_en = !s3_vld || s4_en;
  assign s2_en = !s2_vld || s3_en;
  assign s1_en = !s1_vld || s2_en;

  assign in_stall = !s1_en;

  assign in_item_w.act  = in_action;
  assign in_item_w.x    = in_pixel_x;
  assign in_item_w.addr = in_mem_addr;
  assign in_item_w.data = in_mem_data;

  vmpr_coord #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .VIDEO_BYTES (VIDEO_BYTES)
  ) u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .in_item (in_item_w),
    .in_y    (in_pixel_y),
    .cfg     (cfg_r),
    .s1_en   (s1_en),
    .s2_en   (s2_en),
    .s1_vld  (s1_vld),
    .s2_vld  (s2_vld),
    .fetch   (fetch_w)
  );

  vmpr_vram #(
    .VIDEO_BYTES (VIDEO_BYTES)
  ) u_vram (
    .clk    (clk),
    .rst_n  (rst_n),
    .s2_vld (s2_vld),
    .fetch  (fetch_w),
    .s3_en  (s3_en),
    .s3_vld (s3_vld),
    .code   (code_w)
  );

  vmpr_glyph #(
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_glyph (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_vld    (s3_vld),
    .code      (code_w),
    .cfg       (cfg_r),
    .s4_en     (s4_en),
    .s4_vld    (s4_vld),
    .s4_render (s4_render),
    .colour    (colour_w)
  );

  assign out_valid_nxt = s4_vld && s4_render;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s5_en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en) begin
      out_colour_r <= colour_w;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_colour_index = out_colour_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline still has room");

  a_colour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_colour_index <= COLOUR_BG))
    else $error("colour index beyond the palette");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !s4_vld) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import vmpr_pkg::*;

  localparam int VIDEO_BYTES  = 8192;
  localparam int GLYPH_ROWS   = 12;
  localparam int GLYPH_BYTES  = 256 * GLYPH_ROWS;
  localparam int CHAR_COLS    = 32;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 120;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam logic [3:0] GFX_C2_BASE = 4'd2;
  localparam logic [3:0] CSS_OFFSET  = 4'd4;

  typedef struct {
    logic [1:0]  act;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [12:0] addr;
    logic [7:0]  data;
  } pix_req_t;

  typedef struct {
    int addr;
    int shift;
    bit four;
  } gfx_pos_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_RENDER;
  logic [7:0]  in_pixel_x = '0;
  logic [7:0]  in_pixel_y = '0;
  logic [12:0] in_mem_addr = '0;
  logic [7:0]  in_mem_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_colour_index;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_GFX_EN;
  logic [2:0]  cfg_data = '0;

  // Register copies, changed only while the block is idle.
  logic       cfg_gfx = 1'b0;
  logic       cfg_css = 1'b0;
  logic [2:0] cfg_mode = MODE_64X64_C4;

  // Memory contents as seen by accepted requests.
  logic [7:0] vram_model [VIDEO_BYTES];
  logic [7:0] glyph_model [GLYPH_BYTES];

  // Memory contents as planned by the stimulus, ahead of the driver.
  logic [7:0] vram_plan [VIDEO_BYTES];
  bit         vram_known [VIDEO_BYTES];
  bit         glyph_known [GLYPH_BYTES];

  pix_req_t   pending_reqs[$];
  logic [3:0] expected_colours[$];
  logic [3:0] want_colour;
  int         planned_items;
  int         idle_pct = 0;
  int         stall_pct = 0;
  bit         hold_armed = 1'b0;
  bit         hold_used = 1'b0;
  int         hold_left = 0;
  logic       req_taken = 1'b0;
  bit         failed = 1'b0;
  int         cycles = 0;

  video_mode_pixel_renderer_top #(
    .VIDEO_BYTES(VIDEO_BYTES),
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_mem_addr     (in_mem_addr),
    .in_mem_data     (in_mem_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_colour_index(out_colour_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic gfx_pos_t gfx_locate(logic [2:0] mode, int x, int y);
    gfx_pos_t p;
    int row;
    int stride;
    int scale;
    int col;
    row = y;
    stride = 32;
    scale = 2;
    p.four = 1'b1;
    case (mode)
      MODE_256X192_C2: begin
        scale = 1;
        p.four = 1'b0;
      end
      MODE_128X192_C4: ;
      MODE_128X192_C2: begin
        stride = 16;
        p.four = 1'b0;
      end
      MODE_128X96_C4: row = y / 2;
      MODE_128X96_C2: begin
        row = y / 2;
        stride = 16;
        p.four = 1'b0;
      end
      MODE_128X64_C4: row = y / 3;
      MODE_128X64_C2: begin
        row = y / 3;
        stride = 16;
        p.four = 1'b0;
      end
      default: begin
        row = y / 3;
        stride = 16;
        scale = 4;
      end
    endcase
    col = x / scale;
    // Leftmost pixel of a byte sits in its most significant bits.
    if (p.four) begin
      p.addr = row * stride + col / 4;
      p.shift = 6 - 2 * (col % 4);
    end else begin
      p.addr = row * stride + col / 8;
      p.shift = 7 - col % 8;
    end
    return p;
  endfunction

  function automatic int screen_byte_addr(int x, int y);
    gfx_pos_t p;
    if (cfg_gfx) begin
      p = gfx_locate(cfg_mode, x, y);
      return p.addr;
    end
    return (y / GLYPH_ROWS) * CHAR_COLS + x / 8;
  endfunction

  function automatic logic [3:0] predict_colour(int x, int y);
    gfx_pos_t   p;
    logic [7:0] code;
    logic [7:0] bits;
    logic [7:0] glyph;
    logic [3:0] c;
    if (cfg_gfx) begin
      p = gfx_locate(cfg_mode, x, y);
      code = vram_model[13'(p.addr)];
      bits = code >> p.shift;
      if (p.four) c = {2'b00, bits[1:0]};
      else c = {3'b000, bits[0]} | GFX_C2_BASE;
      if (cfg_css) c = c | CSS_OFFSET;
    end else begin
      code = vram_model[13'((y / GLYPH_ROWS) * CHAR_COLS + x / 8)];
      glyph = glyph_model[12'(int'(code) * GLYPH_ROWS + y % GLYPH_ROWS)];
      // Semigraphic codes draw their own colour on clear glyph bits.
      if (code[7]) c = glyph[3'(x % 8)] ? COLOUR_BG : {1'b0, code[6:4]};
      else c = glyph[3'(x % 8)] ? COLOUR_FG : COLOUR_BG;
    end
    return c;
  endfunction

  task automatic plan_req(logic [1:0] act, logic [7:0] x, logic [7:0] y,
                          logic [12:0] addr, logic [7:0] data);
    pix_req_t r;
    r.act = act;
    r.x = x;
    r.y = y;
    r.addr = addr;
    r.data = data;
    pending_reqs.push_back(r);
    if (act == ACT_WR_VIDEO) begin
      vram_plan[addr] = data;
      vram_known[addr] = 1'b1;
    end
    if (act == ACT_WR_GLYPH && addr < 13'(GLYPH_BYTES)) glyph_known[addr[11:0]] = 1'b1;
    if (act != ACT_NONE && !(act == ACT_WR_GLYPH && addr >= 13'(GLYPH_BYTES)))
      planned_items++;
  endtask

  // Precede the render with whatever writes it needs so that no unwritten
  // entry is ever read.
  task automatic plan_render(int x, int y);
    logic [12:0] a;
    logic [11:0] ga;
    logic [7:0]  code;
    a = 13'(screen_byte_addr(x, y));
    if (!vram_known[a])
      plan_req(ACT_WR_VIDEO, 8'($urandom_range(255)), 8'($urandom_range(255)), a,
               8'($urandom_range(255)));
    if (!cfg_gfx) begin
      code = vram_plan[a];
      ga = 12'(int'(code) * GLYPH_ROWS + y % GLYPH_ROWS);
      if (!glyph_known[ga])
        plan_req(ACT_WR_GLYPH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 {1'b0, ga}, 8'($urandom_range(255)));
    end
    plan_req(ACT_RENDER, 8'(x), 8'(y), 13'($urandom_range(VIDEO_BYTES - 1)),
             8'($urandom_range(255)));
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [2:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GFX_EN: cfg_gfx = val[0];
      CFG_CSS:    cfg_css = val[0];
      CFG_MODE:   cfg_mode = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_colours.size() != 0)
      @(posedge clk);
    // Writes give no result and may still be in the pipeline.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver.
  always @(negedge clk) begin
    pix_req_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_action <= cur.act;
        in_pixel_x <= cur.x;
        in_pixel_y <= cur.y;
        in_mem_addr <= cur.addr;
        in_mem_data <= cur.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long output hold, started once on request.
  always @(negedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // Prediction of accepted requests and checking of results.
  always @(posedge clk) begin
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      case (in_action)
        ACT_RENDER:
          expected_colours.push_back(predict_colour(int'(in_pixel_x),
                                                    int'(in_pixel_y)));
        ACT_WR_VIDEO: vram_model[in_mem_addr] = in_mem_data;
        ACT_WR_GLYPH:
          if (in_mem_addr < 13'(GLYPH_BYTES)) glyph_model[in_mem_addr[11:0]] = in_mem_data;
        default: ;
      endcase
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_colours.size() == 0) begin
        $error("colour_index: unexpected result, actual %0d", out_colour_index);
        failed = 1'b1;
      end else begin
        want_colour = expected_colours.pop_front();
        if (out_colour_index !== want_colour) begin
          $error("colour_index mismatch: expected %0d, actual %0d",
                 want_colour, out_colour_index);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL video_mode_pixel_renderer_top");
      $finish;
    end
  end

  initial begin
    int         ph;
    int         pick;
    int         px;
    int         py;
    int         wa;
    logic       g_en;
    logic       css;
    logic [2:0] mode;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Character mode from reset: plain and semigraphic glyphs, corners,
    // an off-screen line, the unused action and glyph writes past the store.
    plan_req(ACT_WR_GLYPH, 8'd0, 8'd0, 13'd0, 8'hA5);
    plan_req(ACT_WR_GLYPH, 8'd255, 8'd191, 13'(GLYPH_BYTES - 1), 8'h80);
    plan_req(ACT_WR_GLYPH, 8'd0, 8'd0, 13'(8'hF0 * GLYPH_ROWS + 5), 8'h0F);
    plan_req(ACT_WR_VIDEO, 8'd0, 8'd0, 13'd0, 8'h00);
    plan_req(ACT_WR_VIDEO, 8'd0, 8'd0, 13'd1, 8'hF0);
    plan_req(ACT_WR_VIDEO, 8'd0, 8'd0, 13'(15 * CHAR_COLS + 31), 8'hFF);
    plan_req(ACT_WR_VIDEO, 8'hFF, 8'hFF, 13'(VIDEO_BYTES - 1), 8'hFF);
    plan_render(0, 0);
    plan_render(1, 0);
    plan_render(8, 5);
    plan_render(15, 5);
    plan_render(255, 191);
    plan_render(248, 191);
    plan_render(255, 255);
    plan_render(0, 192);
    plan_req(ACT_NONE, 8'hFF, 8'hFF, 13'h1FFF, 8'hFF);
    plan_req(ACT_WR_GLYPH, 8'd0, 8'd0, 13'(GLYPH_BYTES), 8'hFF);
    plan_req(ACT_WR_GLYPH, 8'hFF, 8'hFF, 13'h1FFF, 8'hFF);
    plan_render(0, 0);
    plan_render(7, 0);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 8) begin
        g_en = 1'b1;
        css = ph[0];
        mode = ph[2:0];
      end else if (ph == 8) begin
        g_en = 1'b0;
        css = 1'b0;
        mode = MODE_64X64_C4;
      end else if (ph == 9) begin
        g_en = 1'b1;
        css = 1'b1;
        mode = MODE_256X192_C2;
      end else if (ph == 10) begin
        g_en = 1'b0;
        css = 1'b1;
        mode = MODE_256X192_C2;
      end else begin
        g_en = 1'($urandom_range(1));
        css = 1'($urandom_range(1));
        mode = 3'($urandom_range(7));
      end
      write_cfg(CFG_MODE, mode);
      write_cfg(CFG_CSS, {2'b00, css});
      write_cfg(CFG_GFX_EN, {2'b00, g_en});

      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      // Hold the output off while requests keep coming, to fill the pipeline.
      if (ph == 4) hold_armed = 1'b1;

      planned_items = 0;
      while (planned_items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        px = $urandom_range(255);
        py = ($urandom_range(9) == 0) ? $urandom_range(255, 192) : $urandom_range(191);
        if (pick == 0) begin
          plan_req(ACT_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   13'($urandom_range(VIDEO_BYTES - 1)), 8'($urandom_range(255)));
        end else if (pick < 3) begin
          plan_req(ACT_WR_GLYPH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   13'($urandom_range(8191, GLYPH_BYTES)), 8'($urandom_range(255)));
        end else if (pick < 38) begin
          wa = (pick < 24) ? screen_byte_addr(px, py) : $urandom_range(VIDEO_BYTES - 1);
          plan_req(ACT_WR_VIDEO, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   13'(wa), 8'($urandom_range(255)));
        end else if (pick < 45) begin
          plan_req(ACT_WR_GLYPH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   13'($urandom_range(GLYPH_BYTES - 1)), 8'($urandom_range(255)));
        end else begin
          plan_render(px, py);
        end
      end
      wait_idle();
    end

    if (!failed) $display("PASS video_mode_pixel_renderer_top");
    else $display("FAIL video_mode_pixel_renderer_top");
    $finish;
  end

endmodule
